// ===== hdl/lsp_pkg.sv =====
// Shared types and constants for the looped sample player.
// No dependencies.
`timescale 1ns / 1ps
package lsp_pkg;
  localparam int STORE_AW = 16;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int MAX_CHANNELS = 8;
  localparam logic [39:0] POS_MAX = {40{1'b1}};

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_PLAY  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam logic [2:0] REG_BPS = 3'd0;
  localparam logic [2:0] REG_NCH = 3'd1;
  localparam logic [2:0] REG_LSTART = 3'd2;
  localparam logic [2:0] REG_LEND = 3'd3;
  localparam logic [2:0] REG_RATE = 3'd4;
  localparam logic [2:0] REG_FREQ = 3'd5;
endpackage

// ===== hdl/looped_sample_player.sv =====
// Looped sample player: one sampler voice with a 64K x 24 sample store.
// Play: the item passes two serial multiplies, the one-bit-per-cycle step divider
// and a RAM read before the result is valid; the next item is taken the cycle
// after the result is accepted. A load that closes a frame goes through a serial
// divide by the channel count first. Other loads and clears leave the block idle.
// Synchronous active-high reset clears counters and position, seeds the LFSR and
// sets the config registers to defaults; store stays undefined.
`timescale 1ns / 1ps
module looped_sample_player import lsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,  // raw_sample[23:0], delta_t[55:24], full_period[87:56]
  input  logic [1:0]  s_tuser,  // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // sample_out[23:0]
  output logic        m_tuser,  // from_noise
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  typedef enum logic [3:0] {
    IDLE, LD_DIV, LD_STORE, PL_MUL1, PL_MUL2, PL_DIV, PL_READ, PL_OUT
  } state_t;
  state_t state;

  logic [1:0]  bps;
  logic [3:0]  nch;
  logic [15:0] loop_start, loop_end;
  logic [17:0] rate;
  logic [23:0] freq;
  logic [16:0] loaded_count;
  logic [31:0] channel_sum;
  logic [2:0]  channel_index;
  logic [39:0] pos;
  logic [22:0] lfsr;
  logic [31:0] fp_hold;
  logic [15:0] idx;
  logic [49:0] num;

  // Effective settings.
  logic [3:0] n_eff;
  logic [1:0] bps_eff;
  always_comb begin
    n_eff = (nch == 4'd0) ? 4'd1 : (nch > 4'(MAX_CHANNELS) ? 4'(MAX_CHANNELS) : nch);
    bps_eff = (bps == 2'd0) ? 2'd1 : bps;
  end

  logic [23:0] raw;
  logic [31:0] raw_val;
  always_comb begin
    raw = s_tdata[23:0];
    case (bps_eff)
      2'd2:    raw_val = {{16{raw[15]}}, raw[15:0]};
      2'd3:    raw_val = {{8{raw[23]}}, raw};
      default: raw_val = {24'd0, raw[7:0]};
    endcase
  end

  // Frame scaling: signed dividend, serial divide by n (at most 8).
  logic [31:0] sum_new;
  logic [47:0] ld_dvd;   // magnitude
  logic        ld_neg;
  logic [47:0] ld_q;
  logic [3:0]  ld_rem;
  logic [5:0]  ld_cnt;
  logic [4:0]  ld_trial;
  logic [47:0] scaled;
  logic signed [47:0] sval;
  assign sum_new = channel_sum + raw_val;
  always_comb begin
    case (bps_eff)
      2'd1:    sval = ($signed({{16{sum_new[31]}}, sum_new}) - 48'sd128 * $signed({44'd0, n_eff})) <<< 16;
      2'd2:    sval = $signed({{16{sum_new[31]}}, sum_new}) <<< 8;
      default: sval = $signed({{16{sum_new[31]}}, sum_new});
    endcase
    scaled = sval[47] ? (~sval + 48'd1) : sval;
    ld_trial = {ld_rem, ld_dvd[47]};
  end
  logic [47:0] ld_res;
  assign ld_res = ld_neg ? (~ld_q + 48'd1) : ld_q;

  // Play arithmetic.
  logic        mul_start, div_start, div_done;
  logic [55:0] prod;
  logic [39:0] step;
  logic        mul_done;
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] den;
  lsp_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
                 .prod, .done(mul_done));
  lsp_div u_div (.clk, .rst, .start(div_start), .num, .den, .quo(step),
                 .done(div_done));

  // Store.
  logic        ram_we;
  logic [15:0] ram_addr;
  logic [23:0] ram_q;
  lsp_ram #(.WIDTH(24), .DEPTH(STORE_DEPTH)) u_ram (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(ld_res[23:0]), .rdata(ram_q));
  assign ram_we = (state == LD_STORE) && !loaded_count[16];
  assign ram_addr = (state == LD_STORE) ? loaded_count[15:0] : idx;

  logic [15:0] len;
  logic [15:0] pidx;
  logic        do_loop;
  logic [22:0] lfsr_n;
  logic [37:0] nz_prod;
  always_comb begin
    pidx = pos[39:24];
    do_loop = (loop_end != 16'd0) && (pidx > loop_end) && (loop_start <= loop_end);
    len = loop_end - loop_start;
    lfsr_n = {lfsr[21:0], lfsr[22] ^ lfsr[17]};
    nz_prod = 38'(lfsr_n) * 38'd16777;
  end

  assign s_tready = (state == IDLE) && !m_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      bps <= 2'd2; nch <= 4'd2; loop_start <= '0; loop_end <= '0;
      rate <= 18'd44100; freq <= 24'd112640;
      loaded_count <= '0; channel_sum <= '0; channel_index <= '0;
      pos <= '0; lfsr <= 23'd1; m_tvalid <= 1'b0;
      mul_start <= 1'b0; div_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_BPS:    bps <= cfg_data[1:0];
          REG_NCH:    nch <= cfg_data[3:0];
          REG_LSTART: loop_start <= cfg_data[15:0];
          REG_LEND:   loop_end <= cfg_data[15:0];
          REG_RATE:   rate <= cfg_data[17:0];
          REG_FREQ:   freq <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        IDLE: if (s_tvalid && s_tready) begin
          case (func_t'(s_tuser))
            FUNC_LOAD: begin
              if ({1'b0, channel_index} + 4'd1 < n_eff) begin
                channel_sum <= sum_new;
                channel_index <= channel_index + 3'd1;
              end else begin
                ld_neg <= sval[47];
                ld_dvd <= scaled;
                ld_q <= '0; ld_rem <= '0; ld_cnt <= '0;
                state <= LD_DIV;
              end
            end
            FUNC_PLAY: begin
              if (do_loop) begin
                idx <= pidx - len;
                pos <= pos - {len, 24'd0};
              end else idx <= pidx;
              fp_hold <= s_tdata[87:56];
              mul_a <= s_tdata[55:24];
              mul_b <= {6'd0, rate};
              mul_start <= 1'b1;
              state <= PL_MUL1;
            end
            FUNC_CLEAR: begin
              loaded_count <= '0; channel_sum <= '0; channel_index <= '0;
            end
            default: ;
          endcase
        end
        LD_DIV: begin
          // Remainder below n, so one compare-subtract per bit.
          ld_dvd <= {ld_dvd[46:0], 1'b0};
          if (ld_trial >= {1'b0, n_eff}) begin
            ld_rem <= 4'(ld_trial - {1'b0, n_eff});
            ld_q <= {ld_q[46:0], 1'b1};
          end else begin
            ld_rem <= ld_trial[3:0];
            ld_q <= {ld_q[46:0], 1'b0};
          end
          ld_cnt <= ld_cnt + 6'd1;
          if (ld_cnt == 6'd47) state <= LD_STORE;
        end
        LD_STORE: begin
          if (!loaded_count[16]) loaded_count <= loaded_count + 17'd1;
          channel_sum <= '0; channel_index <= '0;
          state <= IDLE;
        end
        PL_MUL1: if (mul_done) begin
          num <= prod[49:0];
          mul_a <= fp_hold;
          mul_b <= freq;
          mul_start <= 1'b1;
          state <= PL_MUL2;
        end
        PL_MUL2: if (mul_done) begin
          den <= prod;
          div_start <= 1'b1;
          state <= PL_DIV;
        end
        PL_DIV: if (div_done) begin
          pos <= (step > POS_MAX - pos) ? POS_MAX : pos + step;
          state <= PL_READ;
        end
        PL_READ: state <= PL_OUT;
        PL_OUT: begin
          if ({1'b0, idx} < loaded_count) begin
            m_tdata <= ram_q; m_tuser <= 1'b0;
          end else begin
            lfsr <= lfsr_n;
            m_tdata <= 24'(nz_prod[37:23]) - 24'd8388;
            m_tuser <= 1'b1;
          end
          m_tvalid <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/lsp_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module lsp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/lsp_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on lsp_pkg.
`timescale 1ns / 1ps
module lsp_mul import lsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [23:0] b,
  output logic [55:0] prod,
  output logic        done
);
  logic [55:0] acc;
  logic [55:0] mcand;
  logic [23:0] mplier;
  logic [4:0]  cnt;
  logic        busy;

  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        acc    <= '0;
        mcand  <= {24'd0, a};
        mplier <= b;
        cnt    <= 5'd0;
      end else if (busy) begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= {mcand[54:0], 1'b0};
        mplier <= {1'b0, mplier[23:1]};
        cnt    <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hdl/lsp_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
// Computes floor(num*2^32/den) saturated to 40 bits. Depends on lsp_pkg.
`timescale 1ns / 1ps
module lsp_div import lsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [49:0] num,
  input  logic [55:0] den,
  output logic [39:0] quo,
  output logic        done
);
  // num < 2^50 so quotient < 2^82; iterate 82 bits, saturate if upper set.
  localparam int QW = 82;
  logic [QW-1:0] dvd;
  logic [56:0]   rem;
  logic [39:0]   qlo;
  logic          ovf;
  logic [6:0]    cnt;
  logic          busy;
  logic [56:0]   trial;

  assign trial = {rem[55:0], dvd[QW-1]};
  assign quo = (ovf || den == '0) ? POS_MAX : qlo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dvd  <= {num, 32'd0};
        rem  <= '0;
        qlo  <= '0;
        ovf  <= 1'b0;
        cnt  <= '0;
      end else if (busy) begin
        dvd <= {dvd[QW-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          if (cnt < 7'd42) ovf <= 1'b1;
          qlo <= {qlo[38:0], 1'b1};
        end else begin
          rem <= trial;
          qlo <= {qlo[38:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hdl/lsp_checker.sv =====
// Port-level checker for the looped sample player, bound to the top level.
// Depends on lsp_pkg and looped_sample_player.
`timescale 1ns / 1ps
module lsp_props import lsp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);
  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  // No input taken while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken with result pending");
  // Items other than plays give no result next cycle.
  a_noout: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != FUNC_PLAY |=> !m_tvalid)
    else $error("spurious result");
  // Reset leaves no result.
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("valid after reset");
endmodule

bind looped_sample_player lsp_props u_chk (.clk, .rst, .s_tvalid, .s_tready,
  .s_tuser, .m_tvalid, .m_tready, .m_tdata);
